// ----- hdl/pid_filtered_derivative_macros.svh -----
// ---------------------------------------------------------------------------
// pid filtered derivative assertion macros
// shared property shapes for the checker of the pid block
// ---------------------------------------------------------------------------
`ifndef PID_FILTERED_DERIVATIVE_MACROS_SVH
`define PID_FILTERED_DERIVATIVE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfd check failed");

// antecedent implies consequent in the following cycle
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfd check failed");

`endif

// ----- hdl/pfd_pkg.sv -----
// ---------------------------------------------------------------------------
// pfd_pkg
// widths, register indexes, step codes and saturation helper for the
// velocity-form pid block with filtered derivative
// ---------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

  // fixed field widths
  localparam int COEF_W         = 32;
  localparam int OUT_TDATA_W    = 32;
  localparam int SUM_W          = 64;
  localparam int PROD_W         = 2 * COEF_W;

  // parameter defaults
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_FRAC_DEF    = 16;

  // digit-serial multiplier geometry
  localparam int DIGIT_W    = 8;
  localparam int NUM_DIGITS = COEF_W / DIGIT_W;

  // configuration register file
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PI_NOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PI_PREV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_NOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D_PREV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D_OLDER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_IN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FB  = 3'd6;

  // multiply steps of one sample, in issue order
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_PI_NOW  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_PI_PREV = 3'd1;
  localparam logic [STEP_W-1:0] STEP_D_NOW   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_D_PREV  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_D_OLDER = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FILT_FB = 3'd5;
  localparam logic [STEP_W-1:0] STEP_FILT_IN = 3'd6;
  localparam logic [STEP_W-1:0] STEP_LAST    = STEP_FILT_IN;

  // saturation bounds in the wide sum format
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - COEF_W + 1){1'b0}}, {(COEF_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN =
    {{(SUM_W - COEF_W + 1){1'b1}}, {(COEF_W - 1){1'b0}}};

  typedef struct packed {
    logic                     ovf;
    logic [COEF_W-1:0]        val;
  } clamp_t;

  // request into and response out of the serial multiplier
  typedef struct packed {
    logic                     start;
    logic [COEF_W-1:0]        a;
    logic [COEF_W-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic [PROD_W-1:0]        prod;
  } mul_rsp_t;

  // clip a wide sum to the signed 32-bit range
  function automatic clamp_t sat_clamp(input logic signed [SUM_W-1:0] x);
    clamp_t r;
    r.ovf = 1'b0;
    r.val = x[COEF_W-1:0];
    if (x > SAT_MAX) begin
      r.ovf = 1'b1;
      r.val = {1'b0, {(COEF_W - 1){1'b1}}};
    end else if (x < SAT_MIN) begin
      r.ovf = 1'b1;
      r.val = {1'b1, {(COEF_W - 1){1'b0}}};
    end
    return r;
  endfunction

  // coefficient used by each multiply step
  function automatic logic [CFG_IDX_W-1:0] step_reg(input logic [STEP_W-1:0] step);
    logic [CFG_IDX_W-1:0] idx;
    case (step)
      STEP_PI_NOW:  idx = REG_PI_NOW;
      STEP_PI_PREV: idx = REG_PI_PREV;
      STEP_D_NOW:   idx = REG_D_NOW;
      STEP_D_PREV:  idx = REG_D_PREV;
      STEP_D_OLDER: idx = REG_D_OLDER;
      STEP_FILT_FB: idx = REG_GAIN_FB;
      STEP_FILT_IN: idx = REG_GAIN_IN;
      default:      idx = REG_PI_NOW;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pid_filtered_derivative.sv -----
// ---------------------------------------------------------------------------
// pid_filtered_derivative: velocity-form pid, tustin low-pass on derivative
// result: registered in ST_OUT after the products and ST_FIN, later if stalled
// throughput: one sample at a time, 7 serial products per sample
// reset: async active low, clears registers, error history and accumulators
// ---------------------------------------------------------------------------
`default_nettype none

module pid_filtered_derivative #(
  parameter  int SAMPLE_WIDTH   = pfd_pkg::SAMPLE_WIDTH_DEF,
  parameter  int COEF_FRAC_BITS = pfd_pkg::COEF_FRAC_DEF,
  localparam int InTdataW       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [InTdataW-1:0]               s_axis_tdata,  // setpoint, measured
  // drive output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // drive
  output logic                              m_axis_tuser,  // saturated
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfd_pkg::COEF_W-1:0]        cfg_data_i
);
  import pfd_pkg::*;

  localparam int ErrW = SAMPLE_WIDTH + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [STEP_W-1:0]         step_q;
  logic                      start_q;
  logic                      dsum_go_q;
  logic                      sat_q;

  logic signed [ErrW-1:0]    e0_q, e1_q, e2_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [COEF_W-1:0]  acc_pi_q, d0_q, dsum_q, fd0_q;
  logic signed [COEF_W-1:0]  dlast_q, fdlast_q, acc_q;

  logic                      m_valid_q;
  logic [OUT_TDATA_W-1:0]    m_data_q;
  logic                      m_sat_q;

  logic                      in_acc;
  logic                      slot_free;
  logic                      mul_done;
  logic                      last_step;
  logic signed [SAMPLE_WIDTH-1:0] sp, ms;
  logic signed [ErrW-1:0]    e_new;
  logic [COEF_W-1:0]         coef;
  logic [COEF_W-1:0]         operand;
  logic signed [SUM_W-1:0]   prod;
  logic signed [SUM_W-1:0]   prod_shift;
  logic signed [SUM_W-1:0]   addend;
  logic signed [SUM_W-1:0]   sum_next;
  logic                      clamp_step;
  clamp_t                    step_cl, dsum_cl, fin_cl;
  logic                      sat_set;
  mul_req_t                  mul_req;
  mul_rsp_t                  mul_rsp;

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign mul_done      = mul_rsp.done && (state_q == ST_MUL);
  assign last_step     = (step_q == STEP_LAST);

  // error of the incoming sample
  assign sp    = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign ms    = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign e_new = $signed({sp[SAMPLE_WIDTH-1], sp}) - $signed({ms[SAMPLE_WIDTH-1], ms});

  pfd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rd_index_i  (step_reg(step_q)),
    .rd_coef_o   (coef)
  );

  // second multiplier operand per step
  always_comb begin
    case (step_q)
      STEP_PI_NOW:  operand = COEF_W'(e0_q);
      STEP_PI_PREV: operand = COEF_W'(e1_q);
      STEP_D_NOW:   operand = COEF_W'(e0_q);
      STEP_D_PREV:  operand = COEF_W'(e1_q);
      STEP_D_OLDER: operand = COEF_W'(e2_q);
      STEP_FILT_FB: operand = fdlast_q;
      STEP_FILT_IN: operand = dsum_q;
      default:      operand = '0;
    endcase
  end

  assign mul_req.start = start_q;
  assign mul_req.a     = coef;
  assign mul_req.b     = operand;

  pfd_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // fold the finished product into the running sum
  assign prod       = $signed(mul_rsp.prod);
  assign prod_shift = prod >>> COEF_FRAC_BITS;

  always_comb begin
    case (step_q)
      STEP_FILT_FB: addend = -prod_shift;
      STEP_FILT_IN: addend = prod_shift;
      default:      addend = prod;
    endcase
  end

  assign sum_next   = sum_q + addend;
  assign step_cl    = sat_clamp(sum_next);
  assign clamp_step = step_q inside {STEP_PI_PREV, STEP_D_OLDER, STEP_FILT_IN};
  assign dsum_cl    = sat_clamp(SUM_W'(d0_q) + SUM_W'(dlast_q));
  assign fin_cl     = sat_clamp(SUM_W'(acc_pi_q) + SUM_W'(fd0_q));

  assign sat_set = (mul_done && clamp_step && step_cl.ovf) ||
                   (dsum_go_q && dsum_cl.ovf) ||
                   ((state_q == ST_FIN) && fin_cl.ovf);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MUL;
      ST_MUL:  if (mul_done && last_step) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= STEP_PI_NOW;
      start_q   <= 1'b0;
      dsum_go_q <= 1'b0;
      sat_q     <= 1'b0;
      e0_q      <= '0;
      e1_q      <= '0;
      e2_q      <= '0;
      dlast_q   <= '0;
      fdlast_q  <= '0;
      acc_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      start_q   <= in_acc || (mul_done && !last_step);
      dsum_go_q <= mul_done && (step_q == STEP_D_OLDER);
      if (in_acc) begin
        step_q <= STEP_PI_NOW;
        e0_q   <= e_new;
        sat_q  <= 1'b0;
      end else begin
        if (mul_done && !last_step) step_q <= step_q + 1'b1;
        if (sat_set) sat_q <= 1'b1;
      end
      // commit the sample to the loop history
      if (state_q == ST_FIN) begin
        acc_q    <= $signed(fin_cl.val);
        e1_q     <= e0_q;
        e2_q     <= e1_q;
        dlast_q  <= d0_q;
        fdlast_q <= fd0_q;
      end
      if ((state_q == ST_OUT) && slot_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // intermediate sums of the current sample
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum_q <= SUM_W'(acc_q);
    end else if (mul_done) begin
      case (step_q)
        STEP_PI_PREV: begin
          acc_pi_q <= $signed(step_cl.val);
          sum_q    <= '0;
        end
        STEP_D_OLDER: begin
          d0_q  <= $signed(step_cl.val);
          sum_q <= '0;
        end
        STEP_FILT_IN: begin
          fd0_q <= $signed(step_cl.val);
        end
        default: begin
          sum_q <= sum_next;
        end
      endcase
    end
    if (dsum_go_q) begin
      dsum_q <= $signed(dsum_cl.val);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && slot_free) begin
      m_data_q <= acc_q;
      m_sat_q  <= sat_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_sat_q;

endmodule

`default_nettype wire

// ----- hdl/pfd_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// pfd_cfg_regs
// coefficient and gain registers with a write channel and one read port
// ---------------------------------------------------------------------------
`default_nettype none

module pfd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfd_pkg::COEF_W-1:0]      cfg_data_i,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]   rd_index_i,
  output logic [pfd_pkg::COEF_W-1:0]      rd_coef_o
);
  import pfd_pkg::*;

  logic [NUM_REGS-1:0][COEF_W-1:0] regs_q;

  // register writes, out-of-range indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // read port for the sequencer
  assign rd_coef_o = (rd_index_i < CFG_IDX_W'(NUM_REGS)) ? regs_q[rd_index_i] : '0;

endmodule

`default_nettype wire

// ----- hdl/pfd_serial_mul.sv -----
// ---------------------------------------------------------------------------
// pfd_serial_mul
// signed 32 x 32 multiplier, one 8-bit digit of b per cycle, lsb first
// ---------------------------------------------------------------------------
`default_nettype none

module pfd_serial_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfd_pkg::mul_req_t    req_i,
  output pfd_pkg::mul_rsp_t    rsp_o
);
  import pfd_pkg::*;

  localparam int AccW = COEF_W + DIGIT_W + 1;
  localparam int CntW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic signed [COEF_W-1:0]  a_q;
  logic [COEF_W-1:0]         b_q;
  logic signed [AccW-1:0]    hi_q;
  logic [COEF_W-1:0]         lo_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic                      last_digit;
  logic signed [DIGIT_W:0]   digit;
  logic signed [AccW-1:0]    part;
  logic signed [AccW-1:0]    sum_w;

  // top digit of b carries the sign, the others are unsigned
  assign last_digit = (cnt_q == CntW'(NUM_DIGITS - 1));
  assign digit      = $signed({b_q[DIGIT_W-1] & last_digit, b_q[DIGIT_W-1:0]});
  assign part       = a_q * digit;
  assign sum_w      = hi_q + part;

  // digit counter and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 1'b1;
      busy_q <= !last_digit;
      done_q <= last_digit;
    end else begin
      done_q <= 1'b0;
    end
  end

  // partial product shift-accumulate, low digits shift into lo_q
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= $signed(req_i.a);
      b_q  <= req_i.b;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      hi_q <= sum_w >>> DIGIT_W;
      lo_q <= {sum_w[DIGIT_W-1:0], lo_q[COEF_W-1:DIGIT_W]};
      b_q  <= b_q >> DIGIT_W;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q[COEF_W-1:0], lo_q};

endmodule

`default_nettype wire

// ----- hdl/pfd_checker.sv -----
// ---------------------------------------------------------------------------
// pfd_checker
// port-level checks on the pid block, attached to the top level by bind
// ---------------------------------------------------------------------------
`default_nettype none

`include "pid_filtered_derivative_macros.svh"

module pfd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [pfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // drive
  input logic                              m_axis_tuser   // saturated
);

  // a stalled result keeps its value
  `PFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one sample in flight: input closes right after a transaction
  `PFD_ASSERT_NEXT(a_in_closes, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // no result appears the cycle after a sample is taken
  `PFD_ASSERT_NEXT(a_no_instant_out, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

  // a new result coincides with the input reopening
  `PFD_ASSERT_NOW(a_out_reopens, clk_i, rst_ni, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind pid_filtered_derivative pfd_checker u_pfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
